// ===== hw/rtl/dswf_pkg.sv =====
package dswf_pkg;

  localparam int unsigned AltW   = 32;
  localparam int unsigned VarW   = 48;
  localparam int unsigned GainW  = 17;
  localparam int unsigned CntW   = 16;
  localparam int unsigned LimW   = 31;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [GainW-1:0] GainOne = 17'h10000;
  localparam logic [CntW-1:0]  CntSat  = 16'hFFFF;

  localparam logic [CfgIdxW-1:0] RegMeanGain  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegVarGain   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegVarFloor  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDisLimit  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFaultCnt  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStuckCnt  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegStuckInfl = 3'd6;

  typedef struct packed {
    logic [GainW-1:0] mean_gain;
    logic [GainW-1:0] var_gain;
    logic [VarW-1:0]  var_floor;
    logic [LimW-1:0]  dis_limit;
    logic [CntW-1:0]  fault_cnt;
    logic [CntW-1:0]  stuck_cnt;
    logic [VarW-1:0]  stuck_infl;
  } cfg_t;

endpackage

// ===== hw/rtl/dswf_mul.sv =====
module dswf_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] p_o
);
  import dswf_pkg::*;

  logic [127:0] acc_q, acc_d, sh_q, sh_d;
  logic [63:0]  mb_q, mb_d;
  logic [6:0]   cnt_q, cnt_d;
  logic         busy_q, busy_d, done_q, done_d;

  always_comb begin
    acc_d = acc_q; sh_d = sh_q; mb_d = mb_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      acc_d = '0; sh_d = {64'd0, a_i}; mb_d = b_i; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (mb_q[0]) acc_d = acc_q + sh_q;
      sh_d = sh_q << 1;
      mb_d = mb_q >> 1;
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; sh_q <= sh_d; mb_q <= mb_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule

// ===== hw/rtl/dswf_div.sv =====
module dswf_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] n_i,
  input  logic [63:0] d_i,
  output logic        done_o,
  output logic [63:0] q_o
);
  import dswf_pkg::*;

  logic [63:0] q_q, q_d, d_q, d_d;
  logic [64:0] r_q, r_d, t;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;

  always_comb begin
    q_d = q_q; d_d = d_q; r_d = r_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    t = '0;
    if (start_i) begin
      q_d = n_i; d_d = d_i; r_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      t = {r_q[63:0], q_q[63]};
      if (t >= {1'b0, d_q}) begin
        r_d = t - {1'b0, d_q};
        q_d = {q_q[62:0], 1'b1};
      end else begin
        r_d = t;
        q_d = {q_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; d_q <= d_d; r_q <= r_d;
  end

  assign done_o = done_q;
  assign q_o    = q_q;
endmodule

// ===== hw/rtl/dual_sensor_weighted_fusion_top.sv =====
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tdata: altitude_a[31:0], altitude_b[63:32]
// m_axis    out  m_axis_tvalid/tready   tdata: fused_altitude[31:0]; tuser: a_ok, b_ok
// cfg       in   cfg_valid_i/ready_o    cfg_index_i, cfg_data_i
// Each serial multiply or divide runs 64 steps between its start and its done strobe.
// A trusted sensor needs four of them; the blend adds two, each partly stuck sensor four.
// Reset restores register defaults and sensor state; no clearing pass. A finished result
// waits in the output register while the next item is taken; config transfers are taken
// only while the sequencer is idle.
module dual_sensor_weighted_fusion_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // altitude_a, altitude_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // fused_altitude
  output logic [1:0]  m_axis_tuser,   // sensor_a_ok, sensor_b_ok
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import dswf_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0,  S_MA   = 5'd1,  S_MAW  = 5'd2,  S_SQ   = 5'd3,
                         S_SQW  = 5'd4,  S_V1   = 5'd5,  S_V1W  = 5'd6,  S_V2   = 5'd7,
                         S_V2W  = 5'd8,  S_NEXT = 5'd9,  S_DIS  = 5'd10, S_E1   = 5'd11,
                         S_E1W  = 5'd12, S_E2   = 5'd13, S_E2W  = 5'd14, S_E3   = 5'd15,
                         S_E3W  = 5'd16, S_E4   = 5'd17, S_E4W  = 5'd18, S_SHR  = 5'd19,
                         S_W    = 5'd20, S_WW   = 5'd21, S_F    = 5'd22, S_FW   = 5'd23,
                         S_OUT  = 5'd24;

  cfg_t cfg_q;
  logic [4:0] st_q, st_d;
  logic signed [AltW-1:0] prev_a_q, prev_b_q, mean_a_q, mean_b_q, a_q, b_q;
  logic [CntW-1:0] rc_a_q, rc_b_q, dis_q;
  logic ha_q, hb_q, sens_q;
  logic [VarW-1:0] var_a_q, var_b_q;
  logic [VarW:0] ea_q, eb_q, t_q;
  logic [AltW:0] r_q;
  logic [47:0] sq_q;
  logic [63:0] acc_q;
  logic [16:0] w_q;
  logic ov_q;
  logic [31:0] out_q;
  logic [1:0] outu_q;
  logic ovalid_q;

  logic mstart, dstart, mdone, ddone;
  logic [63:0] ma, mb, dn, dd, dq;
  logic [127:0] mp;

  logic [GainW-1:0] gm, gv;
  assign gm = (cfg_q.mean_gain > GainOne) ? GainOne : cfg_q.mean_gain;
  assign gv = (cfg_q.var_gain > GainOne) ? GainOne : cfg_q.var_gain;

  dswf_mul u_mul (.clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb),
                  .done_o(mdone), .p_o(mp));
  dswf_div u_div (.clk_i, .rst_ni, .start_i(dstart), .n_i(dn), .d_i(dd),
                  .done_o(ddone), .q_o(dq));

  logic signed [AltW-1:0] x_cur, m_cur;
  logic [VarW-1:0] v_cur;
  logic [CntW-1:0] c_cur;
  assign x_cur = sens_q ? b_q : a_q;
  assign m_cur = sens_q ? mean_b_q : mean_a_q;
  assign v_cur = sens_q ? var_b_q : var_a_q;
  assign c_cur = sens_q ? rc_b_q : rc_a_q;

  logic signed [AltW:0] dm, dab;
  logic [AltW:0] absd;
  assign dm  = 33'(x_cur) - 33'(m_cur);
  assign dab = 33'(a_q) - 33'(b_q);
  assign absd = dab[AltW] ? 33'(-dab) : 33'(dab);

  // signed multiply via magnitudes
  logic [AltW:0] mag_dm, mag_dba;
  logic signed [AltW:0] dba;
  assign dba = 33'(b_q) - 33'(a_q);
  assign mag_dm  = dm[AltW] ? 33'(-dm) : 33'(dm);
  assign mag_dba = dba[AltW] ? 33'(-dba) : 33'(dba);

  logic signed [64:0] sprod;
  logic signed [AltW:0] mnew, rnew;
  logic [AltW:0] absr;
  logic [63:0] vsum;
  logic [VarW-1:0] vnew_full;
  logic [VarW-1:0] vnew;
  logic [VarW:0] esum;
  logic [VarW+1:0] sumab;
  logic dis_hit, isol_a;
  logic [CntW-1:0] dis_inc;
  logic sa, sb;
  logic signed [64:0] fprod;
  logic signed [48:0] fadj;

  always_comb begin
    sprod = dm[AltW] ? -65'(mp[63:0]) : 65'(mp[63:0]);
    mnew  = 33'(m_cur) + 33'((sprod + 65'sd32768) >>> 16);
    rnew  = 33'(x_cur) - mnew;
    absr  = rnew[AltW] ? 33'(-rnew) : 33'(rnew);
    vsum  = acc_q + mp[63:0] + 64'd32768;
    vnew_full = vsum[63:16];
    vnew  = (vnew_full < cfg_q.var_floor) ? cfg_q.var_floor : vnew_full;
    esum  = ea_q + eb_q;
    sumab = {1'b0, ea_q} + {1'b0, eb_q};
    dis_hit = absd > {2'b0, cfg_q.dis_limit};
    dis_inc = (dis_q < CntSat) ? dis_q + 16'd1 : dis_q;
    sa = rc_a_q >= cfg_q.stuck_cnt;
    sb = rc_b_q >= cfg_q.stuck_cnt;
    isol_a = (sa && !sb) || ((sa == sb) && (var_a_q > var_b_q));
    fprod = dba[AltW] ? -65'(mp[64:0]) : 65'(mp[64:0]);
    fadj  = 49'((fprod + 65'sd32768) >>> 16);
  end

  assign s_axis_tready = (st_q == S_IDLE);
  assign cfg_ready_o   = (st_q == S_IDLE);

  always_comb begin
    mstart = 1'b0; dstart = 1'b0;
    ma = '0; mb = '0; dn = '0; dd = 64'd1;
    unique case (st_q)
      S_MA: begin mstart = 1'b1; ma = 64'(gm); mb = 64'(mag_dm); end
      S_SQ: begin mstart = 1'b1; ma = 64'(r_q[31:0]); mb = 64'(r_q[31:0]); end
      S_V1: begin mstart = 1'b1; ma = 64'(GainOne - gv); mb = 64'(v_cur); end
      S_V2: begin mstart = 1'b1; ma = 64'(gv); mb = 64'(sq_q); end
      S_E1: begin mstart = 1'b1; ma = 64'(cfg_q.stuck_infl); mb = 64'(c_cur); end
      S_E2: begin dstart = 1'b1; dn = mp[63:0]; dd = 64'(cfg_q.stuck_cnt); end
      S_E3: begin mstart = 1'b1; ma = dq; mb = 64'(c_cur); end
      S_E4: begin dstart = 1'b1; dn = mp[63:0]; dd = 64'(cfg_q.stuck_cnt); end
      S_W:  begin dstart = 1'b1; dn = {ea_q[47:0], 16'd0} + 64'(esum >> 1);
                  dd = 64'(esum); end
      S_F:  begin mstart = 1'b1; ma = 64'(w_q); mb = 64'(mag_dba); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mean_gain: 17'd6554, var_gain: 17'd655, var_floor: 48'd42950,
                 dis_limit: 31'd327680, fault_cnt: 16'd10, stuck_cnt: 16'd50,
                 stuck_infl: 48'd429496729600};
      st_q <= S_IDLE; prev_a_q <= '0; prev_b_q <= '0; rc_a_q <= '0; rc_b_q <= '0;
      ha_q <= 1'b1; hb_q <= 1'b1; mean_a_q <= '0; mean_b_q <= '0;
      var_a_q <= '0; var_b_q <= '0; dis_q <= '0; ovalid_q <= 1'b0; sens_q <= 1'b0;
      t_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegMeanGain:  cfg_q.mean_gain  <= cfg_data_i[16:0];
          RegVarGain:   cfg_q.var_gain   <= cfg_data_i[16:0];
          RegVarFloor:  cfg_q.var_floor  <= cfg_data_i[47:0];
          RegDisLimit:  cfg_q.dis_limit  <= cfg_data_i[30:0];
          RegFaultCnt:  cfg_q.fault_cnt  <= cfg_data_i[15:0];
          RegStuckCnt:  cfg_q.stuck_cnt  <= cfg_data_i[15:0];
          RegStuckInfl: cfg_q.stuck_infl <= cfg_data_i[47:0];
          default: ;
        endcase
      end
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (st_q)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          a_q <= s_axis_tdata[31:0]; b_q <= s_axis_tdata[63:32];
          prev_a_q <= s_axis_tdata[31:0]; prev_b_q <= s_axis_tdata[63:32];
          rc_a_q <= (s_axis_tdata[31:0] != prev_a_q) ? '0 :
                    (rc_a_q < CntSat) ? rc_a_q + 16'd1 : rc_a_q;
          rc_b_q <= (s_axis_tdata[63:32] != prev_b_q) ? '0 :
                    (rc_b_q < CntSat) ? rc_b_q + 16'd1 : rc_b_q;
          sens_q <= 1'b0;
          st_q <= ha_q ? S_MA : S_NEXT;
        end
        S_MA: st_q <= S_MAW;
        S_MAW: if (mdone) begin
          if (sens_q) mean_b_q <= mnew[31:0]; else mean_a_q <= mnew[31:0];
          ov_q <= absr[32];
          r_q <= absr;
          st_q <= S_SQ;
        end
        S_SQ: st_q <= S_SQW;
        S_SQW: if (mdone) begin
          sq_q <= (ov_q || (mp[63:48] != 16'd0)) ? 48'hFFFF_FFFF_FFFF : mp[47:0];
          st_q <= S_V1;
        end
        S_V1: st_q <= S_V1W;
        S_V1W: if (mdone) begin acc_q <= mp[63:0]; st_q <= S_V2; end
        S_V2: st_q <= S_V2W;
        S_V2W: if (mdone) begin
          if (sens_q) var_b_q <= vnew; else var_a_q <= vnew;
          st_q <= S_NEXT;
        end
        S_NEXT: begin
          if (!sens_q) begin
            sens_q <= 1'b1;
            st_q <= hb_q ? S_MA : S_DIS;
          end else st_q <= S_DIS;
        end
        S_DIS: begin
          if (!ha_q) begin out_q <= b_q; st_q <= S_OUT; end
          else if (!hb_q) begin out_q <= a_q; st_q <= S_OUT; end
          else if (dis_hit && dis_inc >= cfg_q.fault_cnt) begin
            dis_q <= dis_inc;
            if (isol_a) begin ha_q <= 1'b0; out_q <= b_q; end
            else begin hb_q <= 1'b0; out_q <= a_q; end
            st_q <= S_OUT;
          end else begin
            if (dis_hit) dis_q <= dis_inc;
            else if (dis_q != '0) dis_q <= dis_q - 16'd1;
            sens_q <= 1'b0;
            st_q <= S_E1;
          end
        end
        S_E1: begin
          if (c_cur == '0) begin
            t_q <= '0; st_q <= S_E4W;
          end else if (c_cur >= cfg_q.stuck_cnt) begin
            t_q <= 49'(cfg_q.stuck_infl); st_q <= S_E4W;
          end else st_q <= S_E1W;
        end
        S_E1W: if (mdone) st_q <= S_E2;
        S_E2: st_q <= S_E2W;
        S_E2W: if (ddone) st_q <= S_E3;
        S_E3: st_q <= S_E3W;
        S_E3W: if (mdone) st_q <= S_E4;
        S_E4: st_q <= S_E4W;
        S_E4W: if (ddone || t_q != '0 || c_cur == '0 || c_cur >= cfg_q.stuck_cnt) begin
          if (sens_q) eb_q <= 49'(v_cur) + ((c_cur == '0 || c_cur >= cfg_q.stuck_cnt)
                                            ? t_q : 49'(dq));
          else ea_q <= 49'(v_cur) + ((c_cur == '0 || c_cur >= cfg_q.stuck_cnt)
                                     ? t_q : 49'(dq));
          t_q <= '0;
          if (!sens_q) begin sens_q <= 1'b1; st_q <= S_E1; end
          else st_q <= S_SHR;
        end
        S_SHR: begin
          if (sumab >= 50'(1) << 47) begin
            ea_q <= ea_q >> 1; eb_q <= eb_q >> 1;
          end else if (esum == '0) begin
            w_q <= 17'd32768; st_q <= S_F;
          end else st_q <= S_W;
        end
        S_W: st_q <= S_WW;
        S_WW: if (ddone) begin w_q <= dq[16:0]; st_q <= S_F; end
        S_F: st_q <= S_FW;
        S_FW: if (mdone) begin out_q <= 32'(49'(a_q) + fadj); st_q <= S_OUT; end
        S_OUT: if (!ovalid_q) begin
          ovalid_q <= 1'b1; outu_q <= {hb_q, ha_q}; m_axis_tdata <= out_q;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = outu_q;
endmodule

// ===== bench/dual_sensor_weighted_fusion_top_tb.sv =====
module dual_sensor_weighted_fusion_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dswf_pkg::*;

  localparam longint unsigned Mask48 = 64'hFFFF_FFFF_FFFF;
  localparam int unsigned CycleLimit = 6_000_000;

  typedef struct {
    logic [31:0] alt;
    logic        a_ok;
    logic        b_ok;
  } fusion_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  dual_sensor_weighted_fusion_top dut (.*);

  // fusion state and register copy
  longint unsigned cf_mean_gain, cf_var_gain, cf_var_floor, cf_dis_limit;
  longint unsigned cf_fault_cnt, cf_stuck_cnt, cf_stuck_infl;
  longint          last_raw_a, last_raw_b, mean_a, mean_b;
  longint unsigned var_a, var_b;
  int unsigned     rep_a, rep_b, dis_cnt;
  bit              ok_a, ok_b;

  logic [63:0]  pending_alts[$];
  fusion_out_t  fused_expected[$];
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  int unsigned  hold_left = 0;
  int unsigned  cycles = 0;
  int unsigned  mismatches = 0;
  int unsigned  errors = 0;

  // stimulus shaping
  int           track = 0;
  logic [31:0]  gen_last_a = '0, gen_last_b = '0;
  int           frozen_a = 0, frozen_b = 0;

  function automatic longint round16(longint p);
    return (p + 32768) >>> 16;
  endfunction

  task automatic update_stats(ref longint mean, ref longint unsigned spread, input longint x);
    longint unsigned gm, gv, ar, sq, v;
    longint m, r;
    gm = cf_mean_gain > 65536 ? 65536 : cf_mean_gain;
    gv = cf_var_gain > 65536 ? 65536 : cf_var_gain;
    m = mean + round16(longint'(gm) * (x - mean));
    r = x - m;
    ar = r < 0 ? -r : r;
    sq = ar * ar;
    if (ar > 64'hFFFF_FFFF || sq > Mask48) sq = Mask48;
    v = ((65536 - gv) * spread + gv * sq + 32768) >> 16;
    if (v < cf_var_floor) v = cf_var_floor;
    mean = m;
    spread = v & Mask48;
  endtask

  function automatic longint unsigned inflated_var(longint unsigned v, int unsigned c);
    longint unsigned t;
    if (c == 0) return v;
    if (c >= cf_stuck_cnt) return v + cf_stuck_infl;
    t = cf_stuck_infl * c / cf_stuck_cnt;
    t = t * c / cf_stuck_cnt;
    return v + t;
  endfunction

  function automatic longint weighted_mix(longint unsigned va, longint unsigned vb,
                                          longint a, longint b);
    longint unsigned sum, w;
    while (va + vb >= (64'd1 << 47)) begin
      va = va >> 1;
      vb = vb >> 1;
    end
    sum = va + vb;
    if (sum == 0) w = 32768;
    else w = ((va << 16) + sum / 2) / sum;
    return a + round16(longint'(w) * (b - a));
  endfunction

  task automatic predict_fusion(input logic [63:0] alts);
    longint a, b, d, fused;
    fusion_out_t res;
    bit sa, sb;
    a = longint'($signed(alts[31:0]));
    b = longint'($signed(alts[63:32]));
    rep_a = (a != last_raw_a) ? 0 : (rep_a < 65535 ? rep_a + 1 : rep_a);
    rep_b = (b != last_raw_b) ? 0 : (rep_b < 65535 ? rep_b + 1 : rep_b);
    last_raw_a = a;
    last_raw_b = b;
    if (ok_a) update_stats(mean_a, var_a, a);
    if (ok_b) update_stats(mean_b, var_b, b);
    if (!ok_a) begin
      fused = b;
    end else if (!ok_b) begin
      fused = a;
    end else begin
      d = a - b;
      if (d < 0) d = -d;
      fused = 0;
      if (d > longint'(cf_dis_limit)) begin
        if (dis_cnt < 65535) dis_cnt++;
        if (dis_cnt >= cf_fault_cnt) begin
          sa = rep_a >= cf_stuck_cnt;
          sb = rep_b >= cf_stuck_cnt;
          if ((sa && !sb) || (sa == sb && var_a > var_b)) begin
            ok_a = 0;
            fused = b;
          end else begin
            ok_b = 0;
            fused = a;
          end
        end
      end else if (dis_cnt > 0) begin
        dis_cnt--;
      end
      if (ok_a && ok_b)
        fused = weighted_mix(inflated_var(var_a, rep_a), inflated_var(var_b, rep_b), a, b);
    end
    res.alt = fused[31:0];
    res.a_ok = ok_a;
    res.b_ok = ok_b;
    fused_expected.push_back(res);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) predict_fusion(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_alts.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_alts.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    fusion_out_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (fused_expected.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected transfer: alt=%h ok=%b", m_axis_tdata,
                                      m_axis_tuser);
        mismatches++;
      end else begin
        exp_res = fused_expected.pop_front();
        if (m_axis_tdata !== exp_res.alt || m_axis_tuser[0] !== exp_res.a_ok ||
            m_axis_tuser[1] !== exp_res.b_ok) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch: alt exp %h got %h, a_ok exp %b got %b, b_ok exp %b got %b",
                     exp_res.alt, m_axis_tdata, exp_res.a_ok, m_axis_tuser[0],
                     exp_res.b_ok, m_axis_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_alts.size() != 0 || s_axis_tvalid || fused_expected.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegMeanGain:  cf_mean_gain = val & 64'h1FFFF;
      RegVarGain:   cf_var_gain = val & 64'h1FFFF;
      RegVarFloor:  cf_var_floor = val & Mask48;
      RegDisLimit:  cf_dis_limit = val & 64'h7FFF_FFFF;
      RegFaultCnt:  cf_fault_cnt = val & 64'hFFFF;
      RegStuckCnt:  cf_stuck_cnt = val & 64'hFFFF;
      RegStuckInfl: cf_stuck_infl = val & Mask48;
      default: ;
    endcase
  endtask

  task automatic write_all(input longint unsigned mg, vg, fl, lim, fc, sc, inf);
    wait_drained();
    repeat (1200) @(posedge clk_i);
    write_reg(RegMeanGain, mg);
    write_reg(RegVarGain, vg);
    write_reg(RegVarFloor, fl);
    write_reg(RegDisLimit, lim);
    write_reg(RegFaultCnt, fc);
    write_reg(RegStuckCnt, sc);
    write_reg(RegStuckInfl, inf);
  endtask

  task automatic push_alts(input logic [31:0] a, input logic [31:0] b);
    pending_alts.push_back({b, a});
    gen_last_a = a;
    gen_last_b = b;
  endtask

  task automatic gen_random(input int n, input int gap_pct);
    logic [31:0] a, b;
    int k;
    repeat (n) begin
      k = $urandom_range(99);
      track = track + $signed($urandom_range(131072)) - 65536;
      a = track + $urandom_range(4096);
      b = a + $urandom_range(65536) - 32768;
      if (k < 8) begin
        a = $urandom;
        b = $urandom;
      end else if (k < 8 + gap_pct) begin
        b = a + (($urandom_range(1)) ? 32'sd1 << $urandom_range(18, 22)
                                     : -(32'sd1 << $urandom_range(18, 22)));
      end
      if (frozen_a == 0 && $urandom_range(99) < 3) frozen_a = $urandom_range(1, 60);
      if (frozen_b == 0 && $urandom_range(99) < 3) frozen_b = $urandom_range(1, 60);
      if (frozen_a > 0) begin
        a = gen_last_a;
        frozen_a--;
      end
      if (frozen_b > 0) begin
        b = gen_last_b;
        frozen_b--;
      end
      push_alts(a, b);
    end
  endtask

  initial begin
    cf_mean_gain = 6554;
    cf_var_gain = 655;
    cf_var_floor = 42950;
    cf_dis_limit = 327680;
    cf_fault_cnt = 10;
    cf_stuck_cnt = 50;
    cf_stuck_infl = 64'd429496729600;
    last_raw_a = 0;
    last_raw_b = 0;
    mean_a = 0;
    mean_b = 0;
    var_a = 0;
    var_b = 0;
    rep_a = 0;
    rep_b = 0;
    dis_cnt = 0;
    ok_a = 1;
    ok_b = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_alts(32'h0, 32'h0);
    push_alts(32'h0, 32'h0);
    push_alts(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_alts(32'h8000_0000, 32'h8000_0000);
    push_alts(32'h7FFF_FFFF, 32'h8000_0000);
    push_alts(32'h8000_0000, 32'h7FFF_FFFF);
    push_alts(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_alts(32'h0000_0001, 32'h0000_0000);
    push_alts(32'h5555_5555, 32'h5555_5555);
    push_alts(32'hAAAA_AAAA, 32'hAAAA_AAAA);
    push_alts(32'hAAAA_AAAA, 32'hAAAA_AAAA);
    push_alts(32'h0005_0000, 32'h0000_0000);
    push_alts(32'h0005_0001, 32'h0000_0000);
    push_alts(32'h0010_0000, 32'h0010_8000);
    push_alts(32'hFFF0_0000, 32'hFFF0_1000);
    push_alts(32'h0001_0000, 32'h0001_0000);
    wait_drained();

    // full mean gain, var gain one below full, zero floor, zero stuck confirm, largest inflation
    write_all(65536, 64'hFFFF_FFFF_FFFE_FFFF, 0, 64'h7FFF_FFFF, 65535, 0, Mask48);
    gen_random(150, 6);
    write_all(64'h1_FFFF, 64'h1_0001, 1, 64'hFFFF_FFFF_FFFF_FFFF, 65535, 1, 1);
    gen_random(40, 6);

    write_all(0, 0, Mask48, 64'h7FFF_FFFF, 65535, 65535, 0);
    tx_idle_pct = 75;
    gen_random(100, 6);

    write_all(6554, 655, $urandom_range(1, 100000), 64'h7FFF_FFFF, 65535,
              $urandom_range(3, 20), {$urandom, $urandom} & Mask48);
    tx_idle_pct = 0;
    rx_stall_pct = 75;
    @(posedge clk_i);
    hold_left <= 6000;
    gen_random(200, 6);

    write_all($urandom_range(65536), $urandom_range(65536), {$urandom, $urandom} & 64'hFFFF_FFFF,
              64'h7FFF_FFFF, 65535, $urandom_range(1, 100), {$urandom, $urandom} & Mask48);
    tx_idle_pct = 26;
    rx_stall_pct = 26;
    gen_random(200, 6);

    // first disagreement isolates a sensor
    write_all(6554, 655, 42950, 327680, 0, 5, 64'd429496729600);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    gen_random(60, 0);
    gen_random(160, 10);

    wait_drained();
    repeat (2000) @(posedge clk_i);
    if (errors == 0 && fused_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
